>>> sv/vau_pkg.sv
// vau_pkg: opcodes, status codes and control types of the vec4 vector unit.
// No dependencies. Used by all modules but vau_queue.
package vau_pkg;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_SADD  = 4'd4;
  localparam logic [3:0] OP_SSUB  = 4'd5;
  localparam logic [3:0] OP_SMUL  = 4'd6;
  localparam logic [3:0] OP_SDIV  = 4'd7;
  localparam logic [3:0] OP_DOT3  = 4'd8;
  localparam logic [3:0] OP_DOT4  = 4'd9;
  localparam logic [3:0] OP_CROSS = 4'd10;
  localparam logic [3:0] OP_MAG   = 4'd11;
  localparam logic [3:0] OP_NORM  = 4'd12;
  localparam logic [3:0] OP_XFORM = 4'd13;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam int MAT_N     = 16;
  localparam int MAT_PAIRS = 8;
  localparam int MAT_EW    = 32;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;

  typedef struct packed {
    logic [3:0] op;
    logic       lng;   // iterative unit needed
    logic       sqrt;  // root pass needed
  } vau_ctl_t;

endpackage

>>> sv/vau_if.sv
// vau_in_if / vau_out_if: valid-ready channels of the vec4 vector unit.
// Depends on nothing; the width parameter follows the lane width.
interface vau_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [3:0]          op;
  logic signed [W-1:0] a_x, a_y, a_z, a_w;
  logic signed [W-1:0] b_x, b_y, b_z, b_w;
  modport source(output valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
  modport sink(input valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
  modport mon(input valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, ready);
endinterface

interface vau_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r_x, r_y, r_z, r_w;
  logic [1:0]          status;
  modport source(output valid, r_x, r_y, r_z, r_w, status, input ready);
  modport sink(input valid, r_x, r_y, r_z, r_w, status, output ready);
  modport mon(input valid, r_x, r_y, r_z, r_w, status, ready);
endinterface

>>> sv/vec4_alu_with_matrix_transform_unit.sv
// vec4_alu_with_matrix_transform_unit: four-lane fixed-point vector unit.
// Depends on vau_pkg, vau_if, vau_regs, vau_front, vau_queue, vau_back.
//
// Usage:
//   in_ch  : valid/ready item of opcode plus operand vectors a and b.
//   out_ch : valid/ready result item of four lanes plus a status code.
//   cfg_*  : APB port, 64-bit registers at 8*i holding matrix entry pairs.
// Pipeline: add, sub, mul, dot, cross and transform pass from acceptance to
//   out_ch.valid through the queue, then product register, then output
//   register, and sustain one item per cycle while out_ch is not stalled
//   and the root/divide unit is idle. Divide runs a divide pass, magnitude a
//   root pass, normalize a root then a divide pass; the shared unit works one
//   quotient or root bit per cycle and holds later items until it finishes.
// Reset: synchronous, active low; empties the queue and pipeline and loads
//   the identity matrix.
// Stall: the output register holds its item while out_ch.ready is low; the
//   product stage and the two-entry queue keep filling, then in_ch.ready drops.
// Write configuration only while the unit is empty; the block does not check.
module vec4_alu_with_matrix_transform_unit import vau_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int LANE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  vau_in_if.sink            in_ch,
  vau_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);
  localparam int W  = LANE_WIDTH;
  localparam int CB = $bits(vau_ctl_t);
  localparam int DW = CB + 8 * W;

  logic signed [MAT_EW-1:0] mat [MAT_N];
  logic                     f_valid, f_ready, b_valid, b_ready;
  vau_ctl_t                 f_ctl, b_ctl;
  logic signed [W-1:0]      f_a [4];
  logic signed [W-1:0]      f_b [4];
  logic signed [W-1:0]      b_a [4];
  logic signed [W-1:0]      b_b [4];
  logic [DW-1:0]            f_data, b_data;

  vau_regs #(.F(FRAC_BITS)) u_regs (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready), .mat(mat)
  );

  vau_front #(.W(W)) u_front (
    .in_ch(in_ch), .push_valid(f_valid), .push_ready(f_ready),
    .push_ctl(f_ctl), .push_a(f_a), .push_b(f_b)
  );

  assign f_data = {f_ctl, f_a[0], f_a[1], f_a[2], f_a[3], f_b[0], f_b[1], f_b[2], f_b[3]};

  vau_queue #(.DW(DW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  assign {b_ctl, b_a[0], b_a[1], b_a[2], b_a[3], b_b[0], b_b[1], b_b[2], b_b[3]} = b_data;

  vau_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_ready(b_ready), .q_ctl(b_ctl),
    .q_a(b_a), .q_b(b_b), .mat(mat), .out_ch(out_ch)
  );

endmodule

>>> sv/vau_regs.sv
// vau_regs: APB register file holding the 4x4 transform matrix.
// Depends on vau_pkg.
module vau_regs import vau_pkg::*; #(
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready,
  output logic signed [MAT_EW-1:0] mat [MAT_N]
);
  localparam logic [CFG_DW-1:0] ONE_LO = CFG_DW'(MAT_EW'(1) << F);
  localparam logic [CFG_DW-1:0] ONE_HI = ONE_LO << MAT_EW;

  logic [CFG_DW-1:0] mat_r [MAT_PAIRS];
  logic [2:0]        idx;

  assign idx        = cfg_paddr[CFG_AW-1:3];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = mat_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_PAIRS; i++) begin
        mat_r[i] <= (i == 0 || i == 5) ? ONE_LO : ((i == 2 || i == 7) ? ONE_HI : '0);
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      mat_r[idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int k = 0; k < MAT_N; k++) begin
      mat[k] = mat_r[k/2][(k%2)*MAT_EW +: MAT_EW];
    end
  end

endmodule

>>> sv/vau_front.sv
// vau_front: accepts items, classifies the opcode, broadcasts the scalar operand.
// Depends on vau_pkg and vau_in_if.
module vau_front import vau_pkg::*; #(
  parameter int W = 32
) (
  vau_in_if.sink              in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output vau_ctl_t            push_ctl,
  output logic signed [W-1:0] push_a [4],
  output logic signed [W-1:0] push_b [4]
);
  logic scalar;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign scalar      = !in_ch.op[3] && in_ch.op[2];

  always_comb begin
    push_ctl.op = in_ch.op;
    unique case (in_ch.op) inside
      OP_DIV, OP_SDIV: begin
        push_ctl.lng  = 1'b1;
        push_ctl.sqrt = 1'b0;
      end
      OP_MAG, OP_NORM: begin
        push_ctl.lng  = 1'b1;
        push_ctl.sqrt = 1'b1;
      end
      default: begin
        push_ctl.lng  = 1'b0;
        push_ctl.sqrt = 1'b0;
      end
    endcase
  end

  assign push_a[0] = in_ch.a_x;
  assign push_a[1] = in_ch.a_y;
  assign push_a[2] = in_ch.a_z;
  assign push_a[3] = in_ch.a_w;
  assign push_b[0] = in_ch.b_x;
  assign push_b[1] = scalar ? in_ch.b_x : in_ch.b_y;
  assign push_b[2] = scalar ? in_ch.b_x : in_ch.b_z;
  assign push_b[3] = scalar ? in_ch.b_x : in_ch.b_w;

endmodule

>>> sv/vau_queue.sv
// vau_queue: two-entry item queue between the front and the back.
// Depends on nothing.
module vau_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/vau_back.sv
// vau_back: product stage, result/saturation stage, and the shared iterative
// root/divide unit. Depends on vau_pkg and vau_out_if.
module vau_back import vau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  vau_ctl_t                 q_ctl,
  input  logic signed [W-1:0]      q_a [4],
  input  logic signed [W-1:0]      q_b [4],
  input  logic signed [MAT_EW-1:0] mat [MAT_N],
  vau_out_if.source                out_ch
);
  localparam int XW = (W > MAT_EW) ? W : MAT_EW;
  localparam int PW = XW + W;
  localparam int SW = PW + 2;
  localparam int QW = W + F;
  localparam int RW = W + 2;
  localparam int TW = 2 * (W + 1);
  localparam int CW = $clog2(QW + 1);
  localparam logic [SW-1:0] LMAXP = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic [SW-1:0] LMINV = SW'(1) << (W - 1);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_ROOT = 2'd1;
  localparam logic [1:0] SQ_DIV  = 2'd2;
  localparam logic [1:0] SQ_DONE = 2'd3;

  function automatic logic [W:0] sat_mag(input logic neg, input logic [SW-1:0] m);
    logic [SW-1:0] nm;
    nm = SW'(0) - m;
    if (!neg) begin
      if (m > LMAXP) return {1'b1, LMAXP[W-1:0]};
      return {1'b0, m[W-1:0]};
    end
    if (m > LMINV) return {1'b1, LMINV[W-1:0]};
    return {1'b0, nm[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_val(input logic signed [SW-1:0] v, input logic shf);
    logic          neg;
    logic [SW-1:0] m;
    neg = v[SW-1];
    m   = neg ? SW'(~v + SW'(1)) : SW'(v);
    if (shf) m = m >> F;
    return sat_mag(neg, m);
  endfunction

  // ---------------- product stage
  logic                     s1_v_r;
  vau_ctl_t                 s1_ctl_r;
  logic signed [W-1:0]      s1_a_r [4];
  logic signed [W-1:0]      s1_b_r [4];
  logic signed [PW-1:0]     s1_p_r [MAT_N];
  logic signed [XW-1:0]     mx [MAT_N];
  logic signed [W-1:0]      my [MAT_N];
  logic                     adv, busy, s1_go, wr_pipe, wr_seq;
  logic [1:0]               sq_st_r;

  assign adv     = !out_ch.valid || out_ch.ready;
  assign busy    = sq_st_r != SQ_IDLE;
  assign s1_go   = s1_v_r && !busy && (s1_ctl_r.lng || adv);
  assign q_ready = !s1_v_r || s1_go;
  assign wr_pipe = s1_go && !s1_ctl_r.lng;
  assign wr_seq  = (sq_st_r == SQ_DONE) && adv;

  always_comb begin
    for (int k = 0; k < MAT_N; k++) begin
      mx[k] = '0;
      my[k] = '0;
    end
    unique case (q_ctl.op) inside
      OP_XFORM: begin
        for (int k = 0; k < MAT_N; k++) begin
          mx[k] = XW'(mat[k]);
          my[k] = q_a[k%4];
        end
      end
      OP_MAG, OP_NORM: begin
        for (int k = 0; k < 4; k++) begin
          mx[k] = XW'(q_a[k]);
          my[k] = q_a[k];
        end
      end
      OP_CROSS: begin
        mx[4] = XW'(q_a[1]); my[4] = q_b[2];
        mx[5] = XW'(q_a[2]); my[5] = q_b[1];
        mx[6] = XW'(q_a[2]); my[6] = q_b[0];
        mx[7] = XW'(q_a[0]); my[7] = q_b[2];
        mx[8] = XW'(q_a[0]); my[8] = q_b[1];
        mx[9] = XW'(q_a[1]); my[9] = q_b[0];
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          mx[k] = XW'(q_a[k]);
          my[k] = q_b[k];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (q_ready) begin
      s1_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      s1_ctl_r <= q_ctl;
      s1_a_r   <= q_a;
      s1_b_r   <= q_b;
      for (int k = 0; k < MAT_N; k++) s1_p_r[k] <= mx[k] * my[k];
    end
  end

  // ---------------- result stage for the single-pass ops
  logic signed [SW-1:0] pe [MAT_N];
  logic signed [SW-1:0] ae [4];
  logic signed [SW-1:0] be [4];
  logic [W:0]           pt [4];
  logic [W-1:0]         p_lane [4];
  logic                 p_sat;

  always_comb begin
    for (int k = 0; k < MAT_N; k++) pe[k] = SW'(s1_p_r[k]);
    for (int i = 0; i < 4; i++) begin
      ae[i] = SW'(s1_a_r[i]);
      be[i] = SW'(s1_b_r[i]);
      pt[i] = '0;
    end
    unique case (s1_ctl_r.op) inside
      OP_ADD, OP_SADD: for (int i = 0; i < 4; i++) pt[i] = sat_val(ae[i] + be[i], 1'b0);
      OP_SUB, OP_SSUB: for (int i = 0; i < 4; i++) pt[i] = sat_val(ae[i] - be[i], 1'b0);
      OP_MUL, OP_SMUL: for (int i = 0; i < 4; i++) pt[i] = sat_val(pe[i], 1'b1);
      OP_DOT3: pt[0] = sat_val(pe[0] + pe[1] + pe[2], 1'b1);
      OP_DOT4: pt[0] = sat_val(pe[0] + pe[1] + pe[2] + pe[3], 1'b1);
      OP_CROSS: begin
        pt[0] = sat_val(pe[4] - pe[5], 1'b1);
        pt[1] = sat_val(pe[6] - pe[7], 1'b1);
        pt[2] = sat_val(pe[8] - pe[9], 1'b1);
      end
      OP_XFORM: begin
        for (int i = 0; i < 4; i++) begin
          pt[i] = sat_val(pe[4*i] + pe[4*i+1] + pe[4*i+2] + pe[4*i+3], 1'b1);
        end
      end
      default: ;
    endcase
    p_sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      p_lane[i] = pt[i][W-1:0];
      p_sat     = p_sat | pt[i][W];
    end
  end

  // ---------------- iterative root / divide unit
  vau_ctl_t         sq_ctl_r;
  logic [CW-1:0]    cnt_r;
  logic [TW-1:0]    ss_r;
  logic [W+1:0]     rsq_r;
  logic [W:0]       root_r;
  logic [QW-1:0]    n_r [4];
  logic [W:0]       d_r [4];
  logic [RW-1:0]    rem_r [4];
  logic [QW-1:0]    q_r [4];
  logic             asg_r [4];
  logic             bsg_r [4];

  logic [W+3:0]     r_sh, r_tr, r_df;
  logic             r_ge;
  logic [W:0]       root_nxt;
  logic [W+1:0]     rsq_nxt;
  logic [RW-1:0]    d_sh [4];
  logic             d_ge [4];
  logic [W-1:0]     a_abs [4];
  logic [W-1:0]     b_abs [4];
  logic [TW-1:0]    ss_sum;

  always_comb begin
    r_sh     = {rsq_r, ss_r[TW-1 -: 2]};
    r_tr     = (W+4)'({root_r, 2'b01});
    r_ge     = r_sh >= r_tr;
    r_df     = r_sh - r_tr;
    rsq_nxt  = r_ge ? r_df[W+1:0] : r_sh[W+1:0];
    root_nxt = {root_r[W-1:0], r_ge};
    for (int i = 0; i < 4; i++) begin
      d_sh[i]  = {rem_r[i][RW-2:0], n_r[i][QW-1]};
      d_ge[i]  = d_sh[i] >= RW'(d_r[i]);
      a_abs[i] = s1_a_r[i][W-1] ? W'(~s1_a_r[i] + W'(1)) : s1_a_r[i];
      b_abs[i] = s1_b_r[i][W-1] ? W'(~s1_b_r[i] + W'(1)) : s1_b_r[i];
    end
    ss_sum = TW'(s1_p_r[0]) + TW'(s1_p_r[1]) + TW'(s1_p_r[2]) + TW'(s1_p_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_st_r <= SQ_IDLE;
    end else begin
      unique case (sq_st_r)
        SQ_IDLE: if (s1_go && s1_ctl_r.lng) sq_st_r <= s1_ctl_r.sqrt ? SQ_ROOT : SQ_DIV;
        SQ_ROOT: if (cnt_r == '0) sq_st_r <= (sq_ctl_r.op == OP_MAG) ? SQ_DONE : SQ_DIV;
        SQ_DIV:  if (cnt_r == '0) sq_st_r <= SQ_DONE;
        SQ_DONE: if (adv) sq_st_r <= SQ_IDLE;
        default: sq_st_r <= SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sq_st_r == SQ_IDLE && s1_go && s1_ctl_r.lng) begin
      sq_ctl_r <= s1_ctl_r;
      cnt_r    <= s1_ctl_r.sqrt ? CW'(W) : CW'(QW - 1);
      ss_r     <= ss_sum;
      rsq_r    <= '0;
      root_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        n_r[i]   <= {a_abs[i], F'(0)};
        d_r[i]   <= {1'b0, b_abs[i]};
        rem_r[i] <= '0;
        q_r[i]   <= '0;
        asg_r[i] <= s1_a_r[i][W-1];
        bsg_r[i] <= s1_b_r[i][W-1] && !s1_ctl_r.sqrt;
      end
    end else if (sq_st_r == SQ_ROOT) begin
      cnt_r  <= (cnt_r == '0) ? CW'(QW - 1) : cnt_r - CW'(1);
      ss_r   <= ss_r << 2;
      rsq_r  <= rsq_nxt;
      root_r <= root_nxt;
      if (cnt_r == '0) begin
        for (int i = 0; i < 4; i++) d_r[i] <= root_nxt;
      end
    end else if (sq_st_r == SQ_DIV) begin
      cnt_r <= cnt_r - CW'(1);
      for (int i = 0; i < 4; i++) begin
        rem_r[i] <= d_ge[i] ? d_sh[i] - RW'(d_r[i]) : d_sh[i];
        q_r[i]   <= {q_r[i][QW-2:0], d_ge[i]};
        n_r[i]   <= n_r[i] << 1;
      end
    end
  end

  logic [W:0]   st [4];
  logic [W-1:0] s_lane [4];
  logic         s_sat, s_dz;

  always_comb begin
    s_sat = 1'b0;
    s_dz  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      st[i] = '0;
      if (sq_ctl_r.op != OP_MAG) begin
        if (d_r[i] == '0) begin
          s_dz  = 1'b1;
          st[i] = {1'b0, asg_r[i] ? LMINV[W-1:0] : LMAXP[W-1:0]};
        end else begin
          st[i] = sat_mag(asg_r[i] ^ bsg_r[i], SW'(q_r[i]));
        end
      end
    end
    if (sq_ctl_r.op == OP_MAG) st[0] = sat_mag(1'b0, SW'(root_r));
    for (int i = 0; i < 4; i++) begin
      s_lane[i] = st[i][W-1:0];
      s_sat     = s_sat | st[i][W];
    end
  end

  // ---------------- output register
  logic               o_v_r;
  logic [W-1:0]       o_lane_r [4];
  logic [1:0]         o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (wr_pipe || wr_seq) begin
      o_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pipe) begin
      o_lane_r <= p_lane;
      o_st_r   <= p_sat ? ST_SAT : ST_OK;
    end else if (wr_seq) begin
      o_lane_r <= s_lane;
      o_st_r   <= s_dz ? ST_DZ : (s_sat ? ST_SAT : ST_OK);
    end
  end

  assign out_ch.valid  = o_v_r;
  assign out_ch.r_x    = o_lane_r[0];
  assign out_ch.r_y    = o_lane_r[1];
  assign out_ch.r_z    = o_lane_r[2];
  assign out_ch.r_w    = o_lane_r[3];
  assign out_ch.status = o_st_r;

endmodule

>>> sv/vau_checker.sv
// vau_checker: port-level checks of the vec4 vector unit, bound to the top.
// Depends on vau_pkg and vau_if.
module vau_checker import vau_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  vau_out_if.source out_ch
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_SAT ||
                      out_ch.status == ST_DZ))
    else $error("undefined status code");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.r_x) && $stable(out_ch.r_y) &&
      $stable(out_ch.r_z) && $stable(out_ch.r_w) && $stable(out_ch.status))
    else $error("result changed while stalled");

endmodule

bind vec4_alu_with_matrix_transform_unit vau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_ch(out_ch)
);
